/* hw/rtl/lfps_pkg.sv */
// Shared types, widths and constants of the line follower PID steering core.
`timescale 1ns / 1ps
package lfps_pkg;

    localparam int IntegralBits = 48;        // error integral width, 24..64
    localparam int DutyW        = 15;
    localparam int GainW        = 32;
    localparam int ScaleW       = 15;
    localparam int SteerW       = 24;
    localparam int ErrW         = 17;
    localparam int DerivW       = ErrW + 1;
    localparam int PatW         = 3;
    localparam int CfgIdxW      = 3;
    localparam int CfgDataW     = 32;
    localparam int MulW         = 32;        // shared multiplier operand width
    localparam int ProdW        = 2 * MulW;
    localparam int MagW         = 64;        // term magnitude, split into two halves
    localparam int TermW        = 41;        // clamped product magnitude
    localparam int AccW         = 44;
    localparam int LgW          = ProdW - 24;
    localparam int ScaleShift   = 14;
    localparam int ThirdShift   = 17;

    localparam logic [TermW-1:0]  ProdLim     = TermW'(64'd1 << 40);
    localparam logic [MulW-1:0]   ThirdRecip  = MulW'(43691);
    localparam logic [DutyW-1:0]  DutyMax     = '1;
    localparam logic signed [SteerW-1:0] SteerMax = SteerW'(24'sh7FFFFF);
    localparam logic signed [SteerW-1:0] SteerMin = SteerW'(24'sh800000);

    localparam logic [DutyW-1:0]  MaxSpeedReset  = DutyW'(6144);
    localparam logic [GainW-1:0]  GainPReset     = GainW'(4194304);
    localparam logic [GainW-1:0]  GainIReset     = GainW'(839);
    localparam logic [GainW-1:0]  GainDReset     = GainW'(0);
    localparam logic [ScaleW-1:0] LeftScaleReset  = ScaleW'(16384);
    localparam logic [ScaleW-1:0] RightScaleReset = ScaleW'(16384);

    typedef enum logic [CfgIdxW-1:0] {
        REG_MAX_SPEED   = 3'd0,
        REG_GAIN_P      = 3'd1,
        REG_GAIN_I      = 3'd2,
        REG_GAIN_D      = 3'd3,
        REG_LEFT_SCALE  = 3'd4,
        REG_RIGHT_SCALE = 3'd5
    } lfps_reg_t;

    typedef struct packed {
        logic [DutyW-1:0]  max_speed;
        logic [GainW-1:0]  gain_p;
        logic [GainW-1:0]  gain_i;
        logic [GainW-1:0]  gain_d;
        logic [ScaleW-1:0] left_scale;
        logic [ScaleW-1:0] right_scale;
    } lfps_cfg_t;

endpackage

/* hw/rtl/lfps_sample_if.sv */
// Sensor sample channel: valid/ready handshake carrying one sensor pattern.
`timescale 1ns / 1ps
interface lfps_sample_if import lfps_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [PatW-1:0] sensor_pattern;

    modport source (output valid, output sensor_pattern, input ready);
    modport sink   (input valid, input sensor_pattern, output ready);
endinterface

/* hw/rtl/lfps_result_if.sv */
// Result channel: valid/ready handshake carrying wheel duties and steer value.
`timescale 1ns / 1ps
interface lfps_result_if import lfps_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [DutyW-1:0]         left_duty;
    logic [DutyW-1:0]         right_duty;
    logic signed [SteerW-1:0] steer_value;

    modport source (output valid, output left_duty, output right_duty,
                    output steer_value, input ready);
    modport sink   (input valid, input left_duty, input right_duty,
                    input steer_value, output ready);
endinterface

/* hw/rtl/lfps_cfg_regs.sv */
// Configuration register file of the steering core.
`timescale 1ns / 1ps
module lfps_cfg_regs import lfps_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wen,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,
    output lfps_cfg_t           cfg
);

    lfps_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_speed   <= MaxSpeedReset;
            cfg_reg.gain_p      <= GainPReset;
            cfg_reg.gain_i      <= GainIReset;
            cfg_reg.gain_d      <= GainDReset;
            cfg_reg.left_scale  <= LeftScaleReset;
            cfg_reg.right_scale <= RightScaleReset;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_MAX_SPEED:   cfg_reg.max_speed   <= cfg_data[DutyW-1:0];
                REG_GAIN_P:      cfg_reg.gain_p      <= cfg_data[GainW-1:0];
                REG_GAIN_I:      cfg_reg.gain_i      <= cfg_data[GainW-1:0];
                REG_GAIN_D:      cfg_reg.gain_d      <= cfg_data[GainW-1:0];
                REG_LEFT_SCALE:  cfg_reg.left_scale  <= cfg_data[ScaleW-1:0];
                REG_RIGHT_SCALE: cfg_reg.right_scale <= cfg_data[ScaleW-1:0];
                default: ;  // unmapped index: write dropped
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hw/rtl/lfps_mul.sv */
// Shared 32x32 unsigned multiplier with registered product.
`timescale 1ns / 1ps
module lfps_mul import lfps_pkg::*; (
    input  logic             clk,
    input  logic [MulW-1:0]  a,
    input  logic [MulW-1:0]  b,
    output logic [ProdW-1:0] prod
);

    logic [ProdW-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= ProdW'(a) * ProdW'(b);
    end

    assign prod = prod_reg;

endmodule

/* hw/rtl/line_follower_pid_steering_core.sv */
// Line follower PID steering core: sequencer and datapath around one shared multiplier.
//
// Takes one 3-bit line sensor pattern per request on the sample channel and
// returns one result request (left duty, right duty, PID steer value) on the
// result channel. The pattern is decoded to an error of +-max_speed,
// +-max_speed/2 or zero; centered and full patterns also clear the integral,
// and the all-white and 101 patterns repeat the previous error. The integral
// saturates at IntegralBits. Each PID term is multiplied by its Q8.24 gain as
// a low and a high 32-bit half, truncated toward zero and clamped to +-2^40;
// the sum is saturated to 24 bits. A negative sum slows the left wheel, a
// positive one the right; the fast wheel runs at max_speed times its scale.
// If the slow wheel would go negative it gets 2/3 of max_speed and the
// integral step of this sample is rolled back. A zero sum holds both duties.
// Sequence: after acceptance a sample passes through ST_INTEG, ST_MUL, ST_SAT,
// ST_DUTY and ST_DONE, and sample.ready stays low until the core is back in
// ST_IDLE. The length of this run is set by the single 32x32 multiplier, which
// runs nine products per sample (six for the PID terms, three for the duties
// and the 2/3 fallback). A finished result waits in its own output register,
// so the next sample is accepted while the previous result is still pending;
// a new result is only loaded once the old one has been taken. Configuration is
// to be written by the user through cfg_wen/cfg_index/cfg_data while the core is
// idle; the core does not enforce it. Indexes past the last register are ignored.
`timescale 1ns / 1ps
module line_follower_pid_steering_core import lfps_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    lfps_sample_if.sink         sample,
    lfps_result_if.source       result,
    input  logic                cfg_wen,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data
);

    // sensor codes (bit2 left, bit0 right, 1 = black)
    localparam logic [PatW-1:0] PatRight     = 3'b001;
    localparam logic [PatW-1:0] PatRightHalf = 3'b011;
    localparam logic [PatW-1:0] PatAll       = 3'b111;
    localparam logic [PatW-1:0] PatCenter    = 3'b010;
    localparam logic [PatW-1:0] PatLeftHalf  = 3'b110;
    localparam logic [PatW-1:0] PatLeft      = 3'b100;

    localparam logic signed [IntegralBits-1:0] IntegMax =
        {1'b0, {(IntegralBits-1){1'b1}}};
    localparam logic signed [IntegralBits-1:0] IntegMin =
        {1'b1, {(IntegralBits-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INTEG,   // integral update, derivative
        ST_MUL,     // six gain products, accumulate
        ST_SAT,     // saturate steer value
        ST_DUTY,    // three duty products, hold update
        ST_DONE     // hand off to output register
    } state_t;

    lfps_cfg_t        cfg;
    logic [MulW-1:0]  mul_a;
    logic [MulW-1:0]  mul_b;
    logic [ProdW-1:0] prod;

    state_t                          state_reg;
    logic [2:0]                      step_reg;
    logic signed [ErrW-1:0]          err_reg;
    logic signed [ErrW-1:0]          last_err_reg;
    logic signed [DerivW-1:0]        deriv_reg;
    logic signed [IntegralBits-1:0]  integ_reg;
    logic signed [IntegralBits-1:0]  prev_integ_reg;
    logic [LgW-1:0]                  lg_reg;
    logic signed [AccW-1:0]          acc_reg;
    logic signed [SteerW-1:0]        steer_reg;
    logic [DutyW-1:0]                slow_reg;
    logic [DutyW-1:0]                fast_reg;
    logic [DutyW-1:0]                left_hold_reg;
    logic [DutyW-1:0]                right_hold_reg;
    logic                            out_valid_reg;
    logic [DutyW-1:0]                out_left_reg;
    logic [DutyW-1:0]                out_right_reg;
    logic signed [SteerW-1:0]        out_steer_reg;

    lfps_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lfps_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // ---------------------------------------------------------------
    // Error decode
    // ---------------------------------------------------------------
    logic [DutyW-1:0]       half_speed;
    logic signed [ErrW-1:0] err_dec;
    logic                   integ_clear;

    assign half_speed = cfg.max_speed >> 1;

    always_comb
    begin
        integ_clear = 1'b0;
        case (sample.sensor_pattern)
            PatRight:     err_dec = $signed(ErrW'(cfg.max_speed));
            PatRightHalf: err_dec = $signed(ErrW'(half_speed));
            PatLeftHalf:  err_dec = -$signed(ErrW'(half_speed));
            PatLeft:      err_dec = -$signed(ErrW'(cfg.max_speed));
            PatAll, PatCenter:
            begin
                err_dec     = '0;
                integ_clear = 1'b1;
            end
            default:      err_dec = last_err_reg;   // lost line: keep steering
        endcase
    end

    // ---------------------------------------------------------------
    // Saturating integral step
    // ---------------------------------------------------------------
    logic signed [IntegralBits:0]   integ_wide;
    logic signed [IntegralBits-1:0] integ_next;

    always_comb
    begin
        integ_wide = {integ_reg[IntegralBits-1], integ_reg} + (IntegralBits+1)'(err_reg);
        if (integ_wide[IntegralBits] != integ_wide[IntegralBits-1])
            integ_next = integ_wide[IntegralBits] ? IntegMin : IntegMax;
        else
            integ_next = integ_wide[IntegralBits-1:0];
    end

    // ---------------------------------------------------------------
    // PID term select: 0 = error/gain_p, 1 = integral/gain_i, 2 = derivative/gain_d
    // ---------------------------------------------------------------
    function automatic logic signed [MagW-1:0] term_value(
        input logic [1:0]                     idx,
        input logic signed [ErrW-1:0]         e,
        input logic signed [IntegralBits-1:0] i,
        input logic signed [DerivW-1:0]       d
    );
        case (idx)
            2'd0:    term_value = MagW'(e);
            2'd1:    term_value = MagW'(i);
            default: term_value = MagW'(d);
        endcase
    endfunction

    logic [1:0]             iss_term;
    logic [1:0]             use_term;
    logic [2:0]             use_step;
    logic signed [MagW-1:0] iss_val;
    logic [MagW-1:0]        iss_mag;
    logic signed [MagW-1:0] use_val;
    logic [GainW-1:0]       iss_gain;

    assign iss_term = step_reg[2:1];
    assign use_step = step_reg - 3'd1;
    assign use_term = use_step[2:1];
    assign iss_val  = term_value(iss_term, err_reg, integ_reg, deriv_reg);
    assign use_val  = term_value(use_term, err_reg, integ_reg, deriv_reg);
    assign iss_mag  = iss_val[MagW-1] ? MagW'(-iss_val) : MagW'(iss_val);

    always_comb
    begin
        case (iss_term)
            2'd0:    iss_gain = cfg.gain_p;
            2'd1:    iss_gain = cfg.gain_i;
            default: iss_gain = cfg.gain_d;
        endcase
    end

    // product finish: (hi*g << 8) + (lo*g >> 24), clamped to 2^40
    logic [TermW-1:0]       term_sum;
    logic [TermW-1:0]       term_mag;
    logic signed [AccW-1:0] term_signed;

    always_comb
    begin
        term_sum = {1'b0, prod[MulW-1:0], 8'b0} + TermW'(lg_reg);
        if (|prod[ProdW-1:MulW])
            term_mag = ProdLim;
        else if (term_sum > ProdLim)
            term_mag = ProdLim;
        else
            term_mag = term_sum;
        term_signed = $signed(AccW'(term_mag));
        if (use_val[MagW-1])
            term_signed = -term_signed;
    end

    logic signed [SteerW-1:0] steer_sat;

    always_comb
    begin
        if (acc_reg > AccW'(SteerMax))
            steer_sat = SteerMax;
        else if (acc_reg < AccW'(SteerMin))
            steer_sat = SteerMin;
        else
            steer_sat = acc_reg[SteerW-1:0];
    end

    // ---------------------------------------------------------------
    // Duty selection: slow wheel is left for a negative sum
    // ---------------------------------------------------------------
    logic signed [SteerW:0] slow_val;
    logic                   slow_is_left;
    logic                   too_big;
    logic [ScaleW-1:0]      slow_scale;
    logic [ScaleW-1:0]      fast_scale;
    logic [DutyW-1:0]       scaled_duty;
    logic [DutyW-1:0]       third_duty;
    logic [DutyW-1:0]       slow_duty;

    assign slow_is_left = steer_reg[SteerW-1];
    assign slow_val     = slow_is_left
                        ? $signed((SteerW+1)'(cfg.max_speed)) + (SteerW+1)'(steer_reg)
                        : $signed((SteerW+1)'(cfg.max_speed)) - (SteerW+1)'(steer_reg);
    assign too_big      = slow_val[SteerW];
    assign slow_scale   = slow_is_left ? cfg.left_scale  : cfg.right_scale;
    assign fast_scale   = slow_is_left ? cfg.right_scale : cfg.left_scale;
    assign scaled_duty  = (|prod[ProdW-1:DutyW+ScaleShift]) ? DutyMax
                        : prod[DutyW+ScaleShift-1:ScaleShift];
    assign third_duty   = prod[DutyW+ThirdShift-1:ThirdShift];
    assign slow_duty    = too_big ? third_duty : slow_reg;

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MUL:
            begin
                mul_a = step_reg[0] ? iss_mag[MagW-1:MulW] : iss_mag[MulW-1:0];
                mul_b = iss_gain;
            end
            ST_DUTY:
            begin
                case (step_reg)
                    3'd0:
                    begin
                        mul_a = MulW'(slow_val[DutyW-1:0]);
                        mul_b = MulW'(slow_scale);
                    end
                    3'd1:
                    begin
                        mul_a = MulW'(cfg.max_speed);
                        mul_b = MulW'(fast_scale);
                    end
                    3'd2:
                    begin
                        mul_a = MulW'({cfg.max_speed, 1'b0});
                        mul_b = ThirdRecip;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // output register takes a new result once the old one is gone or leaving
    logic out_load;

    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || result.ready);

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            err_reg        <= '0;
            last_err_reg   <= '0;
            deriv_reg      <= '0;
            integ_reg      <= '0;
            prev_integ_reg <= '0;
            lg_reg         <= '0;
            acc_reg        <= '0;
            steer_reg      <= '0;
            slow_reg       <= '0;
            fast_reg       <= '0;
            left_hold_reg  <= MaxSpeedReset;
            right_hold_reg <= MaxSpeedReset;
            out_valid_reg  <= 1'b0;
            out_left_reg   <= '0;
            out_right_reg  <= '0;
            out_steer_reg  <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                out_left_reg  <= left_hold_reg;
                out_right_reg <= right_hold_reg;
                out_steer_reg <= steer_reg;
            end
            else if (out_valid_reg && result.ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (sample.valid)
                    begin
                        err_reg <= err_dec;
                        if (integ_clear)
                            integ_reg <= '0;
                        state_reg <= ST_INTEG;
                    end
                end

                ST_INTEG:
                begin
                    prev_integ_reg <= integ_reg;
                    integ_reg      <= integ_next;
                    deriv_reg      <= DerivW'(err_reg) - DerivW'(last_err_reg);
                    last_err_reg   <= err_reg;
                    acc_reg        <= '0;
                    step_reg       <= '0;
                    state_reg      <= ST_MUL;
                end

                ST_MUL:
                begin
                    // issue at steps 0..5, consume previous product at 1..6
                    if (step_reg != 3'd0)
                    begin
                        if (!use_step[0])
                            lg_reg <= prod[ProdW-1:24];
                        else
                            acc_reg <= acc_reg + term_signed;
                    end
                    if (step_reg == 3'd6)
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_SAT;
                    end
                    else
                        step_reg <= step_reg + 3'd1;
                end

                ST_SAT:
                begin
                    steer_reg <= steer_sat;
                    step_reg  <= '0;
                    state_reg <= ST_DUTY;
                end

                ST_DUTY:
                begin
                    case (step_reg)
                        3'd1: slow_reg <= scaled_duty;
                        3'd2: fast_reg <= scaled_duty;
                        3'd3:
                        begin
                            if (steer_reg != '0)
                            begin
                                if (slow_is_left)
                                begin
                                    left_hold_reg  <= slow_duty;
                                    right_hold_reg <= fast_reg;
                                end
                                else
                                begin
                                    right_hold_reg <= slow_duty;
                                    left_hold_reg  <= fast_reg;
                                end
                                // slow wheel clamped: roll back this integral step
                                if (too_big)
                                    integ_reg <= prev_integ_reg;
                            end
                        end
                        default: ;
                    endcase
                    if (step_reg == 3'd3)
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_DONE;
                    end
                    else
                        step_reg <= step_reg + 3'd1;
                end

                ST_DONE:
                begin
                    // wait for the output register to free up
                    if (out_load)
                        state_reg <= ST_IDLE;
                end

                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign sample.ready       = (state_reg == ST_IDLE);
    assign result.valid       = out_valid_reg;
    assign result.left_duty   = out_left_reg;
    assign result.right_duty  = out_right_reg;
    assign result.steer_value = out_steer_reg;

endmodule

/* hw/rtl/lfps_chk.sv */
// Port-level checker of the steering core, bound to the top level.
`timescale 1ns / 1ps
module lfps_chk import lfps_pkg::*; (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     sample_valid,
    input logic                     sample_ready,
    input logic                     result_valid,
    input logic                     result_ready,
    input logic [DutyW-1:0]         left_duty,
    input logic [DutyW-1:0]         right_duty,
    input logic signed [SteerW-1:0] steer_value
);

    // core is busy right after taking a sample
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> !sample_ready)
        else $error("sample ready did not drop after accept");

    // no result can appear in the cycle after a sample is taken
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> !$rose(result_valid))
        else $error("result appeared too early");

    // a fresh result comes with the core back to idle
    a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> sample_ready)
        else $error("result raised while core still busy");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(left_duty)
            && $stable(right_duty) && $stable(steer_value))
        else $error("stalled result changed");

endmodule

bind line_follower_pid_steering_core lfps_chk u_lfps_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample.valid),
    .sample_ready (sample.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .left_duty    (result.left_duty),
    .right_duty   (result.right_duty),
    .steer_value  (result.steer_value)
);

/* dv/line_follower_pid_steering_core_tb.sv */
// Testbench of the line follower PID steering core: predicted results versus DUT output.
`timescale 1ns / 1ps
module line_follower_pid_steering_core_tb import lfps_pkg::*; ();

    // ------------------------------------------------------------------
    // Run constants
    // ------------------------------------------------------------------
    localparam int ResetCycles   = 12;
    localparam int DrainCycles   = 24;     // longer than a sample takes from acceptance to result
    localparam int HoldOffCycles = 400;    // long result stall of the pressure test
    localparam int WatchdogLimit = 3000;   // cycles with no request moving on either side
    localparam int MaxPrinted    = 40;

    // Sensor patterns: bit2 left sensor, bit0 right sensor, 1 = black
    localparam logic [PatW-1:0] PatNone      = 3'b000;
    localparam logic [PatW-1:0] PatRightOnly = 3'b001;
    localparam logic [PatW-1:0] PatCenter    = 3'b010;
    localparam logic [PatW-1:0] PatRightPair = 3'b011;
    localparam logic [PatW-1:0] PatLeftOnly  = 3'b100;
    localparam logic [PatW-1:0] PatOuter     = 3'b101;
    localparam logic [PatW-1:0] PatLeftPair  = 3'b110;
    localparam logic [PatW-1:0] PatAll       = 3'b111;

    // Register indexes past the end of the list; writes there must be dropped
    localparam logic [CfgIdxW-1:0] RegSpareA = 3'd6;
    localparam logic [CfgIdxW-1:0] RegSpareB = 3'd7;

    // Result-side stall modes
    localparam int RxAlways   = 0;
    localparam int RxHalf     = 1;
    localparam int RxSparse   = 2;
    localparam int RxPeriodic = 3;

    localparam longint SteerHi = longint'(SteerMax);
    localparam longint SteerLo = longint'(SteerMin);
    localparam bit [63:0] ProductLimit = 64'(ProdLim);

    typedef struct {
        logic [DutyW-1:0]         left;
        logic [DutyW-1:0]         right;
        logic signed [SteerW-1:0] steer;
        logic [PatW-1:0]          pat;
    } steer_result_t;

    // ------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;
    logic                cfg_wen;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgDataW-1:0] cfg_data;

    always #5 clk = ~clk;

    lfps_sample_if sample_bus ();
    lfps_result_if result_bus ();

    line_follower_pid_steering_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_bus),
        .result    (result_bus),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Predictor state: register copy plus the PID and duty-hold state.
    // Duty holds come out of reset at the reset max_speed and are never
    // touched by a max_speed write, only by a nonzero steer sum.
    // ------------------------------------------------------------------
    lfps_cfg_t model_cfg = '{max_speed: MaxSpeedReset, gain_p: GainPReset,
                             gain_i: GainIReset, gain_d: GainDReset,
                             left_scale: LeftScaleReset, right_scale: RightScaleReset};
    longint           pid_last_error = 0;
    longint           pid_integral   = 0;
    logic [DutyW-1:0] left_hold      = MaxSpeedReset;
    logic [DutyW-1:0] right_hold     = MaxSpeedReset;

    steer_result_t expected_steering [$];

    // Bookkeeping
    int mismatch_count   = 0;
    int results_checked  = 0;
    int samples_sent     = 0;
    int settings_applied = 0;
    int fallback_count   = 0;   // slow wheel clipped to 2/3 max, integral rolled back
    int hold_count       = 0;   // zero sum, duties held
    int saturate_count   = 0;   // steer sum clipped to 24 bits

    // Sender burst control
    int burst_left    = 0;
    bit sender_steady = 1'b0;

    // Receiver stall control; hold_off_request is set by a test, served below
    int hold_off_request = 0;
    int hold_off_left    = 0;
    int stall_mode       = RxAlways;
    int mode_left        = 0;
    int rx_phase         = 0;
    int quiet_cycles     = 0;

    // Line position walk for well-formed sensor sequences
    logic [PatW-1:0] track_pattern [5] = '{PatLeftOnly, PatLeftPair, PatCenter,
                                           PatRightPair, PatRightOnly};
    int track_pos = 2;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // (term * gain) >> 24 on the magnitude, so it truncates toward zero,
    // then clipped to +-2^40. Gain multiplies the two 32-bit halves apart.
    function automatic longint gain_product(input longint term, input logic [GainW-1:0] gain);
        bit        neg;
        bit [63:0] mag;
        bit [63:0] hi;
        bit [63:0] lo;
        bit [63:0] r;
        neg = term < 0;
        mag = neg ? 64'(-term) : 64'(term);
        hi  = (mag >> 32) * 64'(gain);
        lo  = (mag & 64'hFFFF_FFFF) * 64'(gain);
        if (hi >= 64'h1_0000_0000)
            r = ProductLimit;
        else
        begin
            r = (hi << 8) + (lo >> 24);
            if (r > ProductLimit)
                r = ProductLimit;
        end
        return neg ? -longint'(r) : longint'(r);
    endfunction

    // Duty times a Q1.14 wheel scale, floored at zero, clipped to 15 bits
    function automatic logic [DutyW-1:0] wheel_duty(input longint v,
                                                    input logic [ScaleW-1:0] scale);
        bit [63:0] p;
        if (v <= 0)
            return '0;
        p = (64'(v) * 64'(scale)) >> ScaleShift;
        return (p > 64'(DutyMax)) ? DutyMax : p[DutyW-1:0];
    endfunction

    // One sensor sample in, one result out; advances the PID state
    function automatic steer_result_t predict_steering(input logic [PatW-1:0] pat);
        steer_result_t r;
        longint m;
        longint h;
        longint err;
        longint deriv;
        longint saved_integral;
        longint imax;
        longint imin;
        longint sum;
        m    = longint'(model_cfg.max_speed);
        h    = m >>> 1;
        imax = longint'((64'd1 << (IntegralBits - 1)) - 64'd1);
        imin = -imax - 1;

        case (pat)
            PatRightOnly: err = m;
            PatRightPair: err = h;
            PatLeftPair:  err = -h;
            PatLeftOnly:  err = -m;
            PatAll, PatCenter:
            begin
                // on the line (or crossing): zero error, integral wiped
                err = 0;
                pid_integral = 0;
            end
            default:      err = pid_last_error;   // line lost: keep steering
        endcase

        saved_integral = pid_integral;
        if (err > 0 && pid_integral > imax - err)
            pid_integral = imax;
        else if (err < 0 && pid_integral < imin - err)
            pid_integral = imin;
        else
            pid_integral += err;

        deriv = err - pid_last_error;
        pid_last_error = err;

        sum = gain_product(err, model_cfg.gain_p)
            + gain_product(pid_integral, model_cfg.gain_i)
            + gain_product(deriv, model_cfg.gain_d);
        if (sum > SteerHi || sum < SteerLo)
            saturate_count++;
        if (sum > SteerHi)
            sum = SteerHi;
        if (sum < SteerLo)
            sum = SteerLo;

        // Negative sum slows the left wheel, positive the right one
        if (sum < 0)
        begin
            if (m + sum < 0)
            begin
                left_hold = DutyW'((2 * m) / 3);
                pid_integral = saved_integral;
                fallback_count++;
            end
            else
                left_hold = wheel_duty(m + sum, model_cfg.left_scale);
            right_hold = wheel_duty(m, model_cfg.right_scale);
        end
        else if (sum > 0)
        begin
            if (m - sum < 0)
            begin
                right_hold = DutyW'((2 * m) / 3);
                pid_integral = saved_integral;
                fallback_count++;
            end
            else
                right_hold = wheel_duty(m - sum, model_cfg.right_scale);
            left_hold = wheel_duty(m, model_cfg.left_scale);
        end
        else
            hold_count++;

        r.left  = left_hold;
        r.right = right_hold;
        r.steer = SteerW'(sum);
        r.pat   = pat;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting: one line per failure, printing capped
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        if (mismatch_count < MaxPrinted)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Configuration port. Writes happen only while the core is idle.
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        // Narrow registers keep only their low bits; spare indexes do nothing
        case (idx)
            REG_MAX_SPEED:   model_cfg.max_speed   = data[DutyW-1:0];
            REG_GAIN_P:      model_cfg.gain_p      = data;
            REG_GAIN_I:      model_cfg.gain_i      = data;
            REG_GAIN_D:      model_cfg.gain_d      = data;
            REG_LEFT_SCALE:  model_cfg.left_scale  = data[ScaleW-1:0];
            REG_RIGHT_SCALE: model_cfg.right_scale = data[ScaleW-1:0];
            default: ;
        endcase
    endtask

    // Random junk above a narrow field, to check the register masks it off
    function automatic logic [CfgDataW-1:0] with_junk(input int width,
                                                      input logic [CfgDataW-1:0] v);
        logic [CfgDataW-1:0] junk;
        logic [CfgDataW-1:0] mask;
        junk = $urandom;
        mask = (CfgDataW'(1) << width) - 1;
        return (junk & ~mask) | (v & mask);
    endfunction

    task automatic program_regs(input lfps_cfg_t c);
        write_reg(REG_MAX_SPEED,   with_junk(DutyW, CfgDataW'(c.max_speed)));
        write_reg(REG_GAIN_P,      c.gain_p);
        write_reg(REG_GAIN_I,      c.gain_i);
        write_reg(REG_GAIN_D,      c.gain_d);
        write_reg(REG_LEFT_SCALE,  with_junk(ScaleW, CfgDataW'(c.left_scale)));
        write_reg(REG_RIGHT_SCALE, with_junk(ScaleW, CfgDataW'(c.right_scale)));
        // spare indexes last, so an aliased decode would clobber a real register
        write_reg(RegSpareA, $urandom);
        write_reg(RegSpareB, $urandom);
        @(posedge clk);
        cfg_wen <= 1'b0;
        settings_applied++;
    endtask

    function automatic lfps_cfg_t random_setting();
        lfps_cfg_t c;
        case ($urandom_range(0, 9))
            0:       c.max_speed = 15'd25600;
            1:       c.max_speed = DutyMax;
            2:       c.max_speed = DutyW'($urandom_range(0, 255));
            default: c.max_speed = DutyW'($urandom_range(0, 25600));
        endcase
        case ($urandom_range(0, 7))
            0:       c.gain_p = '0;
            1:       c.gain_p = '1;
            2:       c.gain_p = $urandom;
            default: c.gain_p = $urandom_range(1 << 20, 1 << 27);
        endcase
        case ($urandom_range(0, 7))
            0:       c.gain_i = '0;
            1:       c.gain_i = '1;
            2:       c.gain_i = $urandom;
            default: c.gain_i = $urandom_range(0, 1 << 18);
        endcase
        case ($urandom_range(0, 7))
            0:       c.gain_d = '0;
            1:       c.gain_d = '1;
            2:       c.gain_d = $urandom;
            default: c.gain_d = $urandom_range(0, 1 << 25);
        endcase
        case ($urandom_range(0, 5))
            0:       c.left_scale = '0;
            1:       c.left_scale = '1;
            2:       c.left_scale = 15'd16384;
            default: c.left_scale = ScaleW'($urandom_range(8192, 24576));
        endcase
        case ($urandom_range(0, 5))
            0:       c.right_scale = '0;
            1:       c.right_scale = '1;
            2:       c.right_scale = 15'd16384;
            default: c.right_scale = ScaleW'($urandom_range(8192, 24576));
        endcase
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Sample side. The sender runs in bursts with random gaps unless
    // sender_steady is set. Prediction happens at the accepting edge.
    // Called and returning at a rising edge.
    // ------------------------------------------------------------------
    task automatic send_sample(input logic [PatW-1:0] pat);
        int gap;
        if (!sender_steady && burst_left == 0)
        begin
            gap = $urandom_range(0, 8);
            if (gap != 0)
            begin
                sample_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left > 0)
            burst_left--;
        sample_bus.valid          <= 1'b1;
        sample_bus.sensor_pattern <= pat;
        @(posedge clk);
        while (!sample_bus.ready)
            @(posedge clk);
        expected_steering.push_back(predict_steering(pat));
        samples_sent++;
    endtask

    // Mostly a line position that drifts one sensor step at a time, with
    // lost-line, crossing and fully random patterns mixed in as noise
    function automatic logic [PatW-1:0] next_pattern();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return PatW'($urandom_range(0, 7));
        if (r < 22)
            return PatNone;
        if (r < 25)
            return PatOuter;
        if (r < 28)
            return PatAll;
        track_pos += $urandom_range(0, 2) - 1;
        if (track_pos < 0)
            track_pos = 0;
        if (track_pos > 4)
            track_pos = 4;
        return track_pattern[track_pos];
    endfunction

    // Stop offering, wait for every predicted result, then let the core settle
    task automatic wait_idle();
        sample_bus.valid <= 1'b0;
        while (expected_steering.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Result side: the stall mode is redrawn at random when its run ends; a test can
    // ask for one long hold-off, counted here.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_stall_pattern
        if (hold_off_request != 0)
        begin
            hold_off_left    = hold_off_request;
            hold_off_request = 0;
        end
        if (hold_off_left > 0)
        begin
            hold_off_left--;
            result_bus.ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(RxAlways, RxPeriodic);
                mode_left  = $urandom_range(16, 128);
            end
            mode_left--;
            rx_phase++;
            case (stall_mode)
                RxAlways: result_bus.ready <= 1'b1;
                RxHalf:   result_bus.ready <= 1'($urandom_range(0, 1));
                RxSparse: result_bus.ready <= ($urandom_range(0, 3) == 0);
                default:  result_bus.ready <= (rx_phase % 5) >= 2;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every accepted result against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        steer_result_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (expected_steering.size() == 0)
                report_mismatch($sformatf(
                    "result with no sample pending: left %0d right %0d steer %0d",
                    result_bus.left_duty, result_bus.right_duty,
                    result_bus.steer_value));
            else
            begin
                want = expected_steering.pop_front();
                results_checked++;
                if (result_bus.left_duty !== want.left)
                    report_mismatch($sformatf("left_duty got %0d expected %0d (pattern %b)",
                                              result_bus.left_duty, want.left, want.pat));
                if (result_bus.right_duty !== want.right)
                    report_mismatch($sformatf("right_duty got %0d expected %0d (pattern %b)",
                                              result_bus.right_duty, want.right, want.pat));
                if (result_bus.steer_value !== want.steer)
                    report_mismatch($sformatf("steer_value got %0d expected %0d (pattern %b)",
                                              result_bus.steer_value, want.steer, want.pat));
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: ends the run if no request moves for too long
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (sample_bus.valid && sample_bus.ready)
                   || (result_bus.valid && result_bus.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WatchdogLimit)
        begin
            $display("[%0t] watchdog: no request moved for %0d cycles, %0d results outstanding",
                     $realtime, quiet_cycles, expected_steering.size());
            $display("line_follower_pid_steering_core_tb failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset register values: first sample with a zero sum shows the duty
    // holds at reset max_speed, then every other pattern (right-only twice),
    // including the lost-line repeat and the integral-clearing patterns.
    task automatic test_reset_state();
        logic [PatW-1:0] seq [9] = '{PatNone, PatRightOnly, PatRightOnly, PatRightPair,
                                     PatCenter, PatLeftPair, PatLeftOnly, PatOuter, PatAll};
        foreach (seq[i])
            send_sample(seq[i]);
        wait_idle();
    endtask

    // Widest register values (with junk above the narrow fields), then a
    // zero left scale with the slow wheel landing exactly on zero duty
    task automatic test_register_extremes();
        logic [PatW-1:0] seq_max [6] = '{PatRightOnly, PatRightOnly, PatLeftOnly,
                                         PatNone, PatCenter, PatLeftPair};
        logic [PatW-1:0] seq_edge [3] = '{PatRightOnly, PatRightPair, PatLeftOnly};
        program_regs('{max_speed: DutyMax, gain_p: '1, gain_i: '1, gain_d: '1,
                       left_scale: '1, right_scale: '1});
        foreach (seq_max[i])
            send_sample(seq_max[i]);
        wait_idle();
        // gain_p = 1.0 makes a full-right error steer by exactly max_speed
        program_regs('{max_speed: 15'd25600, gain_p: 32'h0100_0000, gain_i: '0,
                       gain_d: '0, left_scale: '0, right_scale: '1});
        foreach (seq_edge[i])
            send_sample(seq_edge[i]);
        wait_idle();
    endtask

    // Zero sum keeps both duties; a zero max_speed forces zero error too
    task automatic test_zero_sum_hold();
        program_regs('{max_speed: '0, gain_p: '1, gain_i: '1, gain_d: '1,
                       left_scale: 15'd16384, right_scale: 15'd16384});
        send_sample(PatRightOnly);
        send_sample(PatLeftOnly);
        wait_idle();
        program_regs('{max_speed: 15'd25600, gain_p: '0, gain_i: '0, gain_d: '0,
                       left_scale: 15'd12000, right_scale: 15'd20000});
        send_sample(PatRightOnly);
        send_sample(PatLeftPair);
        wait_idle();
    endtask

    // Gain of 8 pushes the slow wheel below zero: 2/3 max_speed, integral
    // step rolled back (visible through the integral term of later samples)
    task automatic test_slow_wheel_fallback();
        program_regs('{max_speed: 15'd6144, gain_p: 32'h0800_0000, gain_i: 32'h0010_0000,
                       gain_d: 32'h0040_0000, left_scale: 15'd16384, right_scale: 15'd16384});
        send_sample(PatRightOnly);
        send_sample(PatRightOnly);
        send_sample(PatLeftOnly);
        send_sample(PatLeftPair);
        wait_idle();
    endtask

    // Random settings, each followed by a drifting sensor sequence
    task automatic test_random_tracking();
        for (int s = 0; s < 9; s++)
        begin
            program_regs(random_setting());
            for (int n = 0; n < 145; n++)
                send_sample(next_pattern());
            wait_idle();
        end
    endtask

    // Result side held off for a long stretch while samples keep coming:
    // the pending result register fills and the sample side must stall
    task automatic test_output_backpressure();
        program_regs(random_setting());
        hold_off_request = HoldOffCycles;
        sender_steady = 1'b1;
        for (int n = 0; n < 40; n++)
            send_sample(next_pattern());
        sender_steady = 1'b0;
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n                     = 1'b0;
        cfg_wen                   = 1'b0;
        cfg_index                 = '0;
        cfg_data                  = '0;
        sample_bus.valid          = 1'b0;
        sample_bus.sensor_pattern = '0;
        result_bus.ready          = 1'b0;

        repeat (ResetCycles) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_register_extremes();
        test_zero_sum_hold();
        test_slow_wheel_fallback();
        test_random_tracking();
        test_output_backpressure();
        wait_idle();

        $display("Run covered %0d sensor samples over %0d register settings plus reset values",
                 samples_sent, settings_applied);
        $display("%0d results compared: %0d zero-sum holds, %0d slow-wheel fallbacks,",
                 results_checked, hold_count, fallback_count);
        $display("%0d clipped sums, %0d mismatches", saturate_count, mismatch_count);
        if (mismatch_count == 0)
            $display("line_follower_pid_steering_core_tb passed");
        else
            $display("line_follower_pid_steering_core_tb failed");
        $finish;
    end

endmodule
